[sv/arpf_pkg.sv]
package arpf_pkg;

    localparam int BUF_SIZE_DEF = 80;
    localparam int BUF_SIZE_MAX = 80;
    // frame index, wide enough to hold the largest frame size itself
    localparam int IDX_W = $clog2(BUF_SIZE_MAX + 1);

    localparam logic [7:0] START_MARK = 8'h7E;
    localparam logic [7:0] RX_TYPE    = 8'h90;
    localparam logic [7:0] CHK_BASE   = 8'hFF;
    localparam int         PAY_OFFSET = 15;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic [2:0] ST_PAYLOAD  = 3'd0;
    localparam logic [2:0] ST_CHECKSUM = 3'd1;
    localparam logic [2:0] ST_TYPE     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_TIMEOUT  = 3'd5;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic       last_flag;
    } out_word_t;

    // job handed from the parser to the result side
    typedef struct packed {
        logic             drain;
        logic [2:0]       status;
        logic [IDX_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

    typedef struct packed {
        logic drain_done;
        logic draining;
    } bk_stat_t;

endpackage

[sv/api_rx_frame_parser_unit.sv]
// Receive parser for API-mode radio frames carrying a receive packet (type 0x90).
// Input channel (in_valid/in_stall/in_data): one word per received byte or per
// timer tick. Output channel (out_valid/out_stall/out_data): payload bytes of a
// good frame with last_flag on the final one, or one status word per error
// (checksum, wrong type, empty payload, overflow, timeout).
// cfg_write_en/cfg_write_data set the idle timeout in ticks; write only when idle.
// Throughput: one input word per cycle while no payload readout is pending and
// the two-entry job queue between parser and result side has room.
// A frame with a good payload holds in_stall high from the checksum byte until
// the last payload byte enters the output register; the readout passes through
// a read state and an emit state for each byte, set by the single registered read port of the frame buffer.
// A status word passes through the job queue and then the output register; the
// first payload byte passes through the job queue, a buffer read and the output register.
// Reset clears the parser to waiting for a start delimiter, empties the queue
// and the output register, and sets the timeout to 100 ticks. The frame buffer
// is not cleared. A stalled output word holds; the job queue then fills and
// in_stall rises.
module api_rx_frame_parser_unit #(
    parameter int BUF_SIZE = arpf_pkg::BUF_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [15:0]         cfg_write_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  arpf_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output arpf_pkg::out_word_t out_data
);

    logic               push, pop, fifo_full, cmd_valid;
    arpf_pkg::cmd_t     cmd_in, cmd_out;
    arpf_pkg::mem_wr_t  mem_wr;
    arpf_pkg::bk_stat_t bk_stat;

    arpf_front #(
        .BUF_SIZE (BUF_SIZE)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .push           (push),
        .cmd            (cmd_in),
        .fifo_full      (fifo_full),
        .mem_wr         (mem_wr),
        .bk_stat        (bk_stat)
    );

    arpf_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (cmd_in),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (cmd_valid),
        .rd_data   (cmd_out)
    );

    arpf_back #(
        .BUF_SIZE (BUF_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .pop       (pop),
        .mem_wr    (mem_wr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .bk_stat   (bk_stat)
    );

    a_no_write_during_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> !bk_stat.draining)
        else $error("frame buffer overwritten during payload readout");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != arpf_pkg::ST_PAYLOAD)) |->
            (out_data.last_flag && (out_data.payload_byte == 8'h00)))
        else $error("error status word not marked last or carries data");

    a_stall_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.draining |-> in_stall)
        else $error("input accepted during payload readout");

endmodule

[sv/arpf_front.sv]
module arpf_front #(
    parameter int BUF_SIZE = arpf_pkg::BUF_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [15:0]        cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  arpf_pkg::in_word_t in_data,
    output logic               push,
    output arpf_pkg::cmd_t     cmd,
    input  logic               fifo_full,
    output arpf_pkg::mem_wr_t  mem_wr,
    input  arpf_pkg::bk_stat_t bk_stat
);

    localparam int IDX_W = arpf_pkg::IDX_W;

    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_LEN_LO = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] total_reg, total_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       type_reg, type_next;
    logic [15:0]      idle_reg, idle_next;
    logic [15:0]      timeout_reg;
    logic             pend_reg, pend_next;

    logic             accept;
    logic [16:0]      idle_inc;
    logic [16:0]      len_total;
    logic [IDX_W-1:0] wr_idx_inc;
    logic [7:0]       type_seen;
    logic [7:0]       b;

    assign in_stall   = fifo_full || pend_reg;
    assign accept     = in_valid && !in_stall;
    assign b          = in_data.rx_byte;
    assign idle_inc   = {1'b0, idle_reg} + 17'd1;
    assign len_total  = {1'b0, len_hi_reg, b} + 17'd4;
    assign wr_idx_inc = wr_idx_reg + IDX_W'(1);
    // with a zero length word the type byte is the checksum byte itself
    assign type_seen  = (wr_idx_reg == IDX_W'(3)) ? b : type_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        wr_idx_next = wr_idx_reg;
        total_next  = total_reg;
        len_hi_next = len_hi_reg;
        sum_next    = sum_reg;
        type_next   = type_reg;
        idle_next   = idle_reg;
        pend_next   = pend_reg && !bk_stat.drain_done;
        push        = 1'b0;
        cmd.drain   = 1'b0;
        cmd.status  = arpf_pkg::ST_TIMEOUT;
        cmd.count   = '0;
        mem_wr.en   = 1'b0;
        mem_wr.addr = wr_idx_reg;
        mem_wr.data = b;

        if (accept)
        begin
            if (in_data.operation == arpf_pkg::OP_TICK)
            begin
                if (phase_reg != PH_WAIT)
                begin
                    if (idle_inc > {1'b0, timeout_reg})
                    begin
                        push       = 1'b1;
                        cmd.status = arpf_pkg::ST_TIMEOUT;
                        phase_next = PH_WAIT;
                        idle_next  = '0;
                    end
                    else
                    begin
                        idle_next = idle_inc[15:0];
                    end
                end
            end
            else
            begin
                idle_next = '0;
                case (phase_reg)
                    PH_WAIT:
                    begin
                        if (b == arpf_pkg::START_MARK)
                        begin
                            mem_wr.en   = 1'b1;
                            mem_wr.addr = '0;
                            wr_idx_next = IDX_W'(1);
                            sum_next    = '0;
                            phase_next  = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        mem_wr.en   = 1'b1;
                        wr_idx_next = wr_idx_inc;
                        len_hi_next = b;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        mem_wr.en   = 1'b1;
                        wr_idx_next = wr_idx_inc;
                        if (len_total > 17'(BUF_SIZE))
                        begin
                            push       = 1'b1;
                            cmd.status = arpf_pkg::ST_OVERFLOW;
                            phase_next = PH_WAIT;
                        end
                        else
                        begin
                            total_next = len_total[IDX_W-1:0];
                            phase_next = PH_DATA;
                        end
                    end
                    default:
                    begin
                        mem_wr.en   = 1'b1;
                        wr_idx_next = wr_idx_inc;
                        if (wr_idx_reg == IDX_W'(3))
                        begin
                            type_next = b;
                        end
                        if (wr_idx_inc >= total_reg)
                        begin
                            // checksum byte: close the frame
                            push       = 1'b1;
                            phase_next = PH_WAIT;
                            if ((arpf_pkg::CHK_BASE - sum_reg) != b)
                            begin
                                cmd.status = arpf_pkg::ST_CHECKSUM;
                            end
                            else if (type_seen != arpf_pkg::RX_TYPE)
                            begin
                                cmd.status = arpf_pkg::ST_TYPE;
                            end
                            else if (total_reg < IDX_W'(arpf_pkg::PAY_OFFSET + 2))
                            begin
                                cmd.status = arpf_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.drain  = 1'b1;
                                cmd.status = arpf_pkg::ST_PAYLOAD;
                                cmd.count  = total_reg - IDX_W'(arpf_pkg::PAY_OFFSET + 1);
                                pend_next  = 1'b1;
                            end
                        end
                        else
                        begin
                            sum_next = sum_reg + b;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            wr_idx_reg  <= '0;
            total_reg   <= '0;
            len_hi_reg  <= '0;
            sum_reg     <= '0;
            type_reg    <= '0;
            idle_reg    <= '0;
            pend_reg    <= 1'b0;
            timeout_reg <= arpf_pkg::TIMEOUT_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            wr_idx_reg <= wr_idx_next;
            total_reg  <= total_next;
            len_hi_reg <= len_hi_next;
            sum_reg    <= sum_next;
            type_reg   <= type_next;
            idle_reg   <= idle_next;
            pend_reg   <= pend_next;
            if (cfg_write_en)
            begin
                timeout_reg <= cfg_write_data;
            end
        end
    end

    a_no_write_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !mem_wr.en)
        else $error("frame buffer written while payload readout pending");

    a_drain_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cmd.drain) |-> (cmd.count != '0))
        else $error("payload job with zero bytes");

endmodule

[sv/arpf_fifo.sv]
module arpf_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  arpf_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output arpf_pkg::cmd_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    arpf_pkg::cmd_t   slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job queue overrun");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("job queue underrun");

endmodule

[sv/arpf_back.sv]
module arpf_back #(
    parameter int BUF_SIZE = arpf_pkg::BUF_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  arpf_pkg::cmd_t      cmd,
    output logic                pop,
    input  arpf_pkg::mem_wr_t   mem_wr,
    output logic                out_valid,
    input  logic                out_stall,
    output arpf_pkg::out_word_t out_data,
    output arpf_pkg::bk_stat_t  bk_stat
);

    localparam int IDX_W  = arpf_pkg::IDX_W;
    localparam int ADDR_W = $clog2(BUF_SIZE);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_EMIT = 2'd2;

    logic [7:0]          frame_mem [BUF_SIZE];
    logic [7:0]          rd_data_reg;

    logic [1:0]          state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic                out_valid_reg, out_valid_next;
    arpf_pkg::out_word_t out_data_reg, out_data_next;
    logic                out_free;
    logic                done;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign bk_stat.drain_done = done;
    assign bk_stat.draining   = (state_reg != B_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_wr.en && (mem_wr.addr < IDX_W'(BUF_SIZE)))
        begin
            frame_mem[mem_wr.addr[ADDR_W-1:0]] <= mem_wr.data;
        end
        if (state_reg == B_READ)
        begin
            rd_data_reg <= frame_mem[addr_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        done           = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.drain)
                    begin
                        pop        = 1'b1;
                        cnt_next   = cmd.count;
                        addr_next  = IDX_W'(arpf_pkg::PAY_OFFSET);
                        state_next = B_READ;
                    end
                    else if (out_free)
                    begin
                        pop                        = 1'b1;
                        out_valid_next             = 1'b1;
                        out_data_next.status       = cmd.status;
                        out_data_next.payload_byte = 8'h00;
                        out_data_next.last_flag    = 1'b1;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = arpf_pkg::ST_PAYLOAD;
                    out_data_next.payload_byte = rd_data_reg;
                    out_data_next.last_flag    = (cnt_reg == IDX_W'(1));
                    cnt_next                   = cnt_reg - IDX_W'(1);
                    addr_next                  = addr_reg + IDX_W'(1);
                    if (cnt_reg == IDX_W'(1))
                    begin
                        done       = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        addr_reg     <= addr_next;
        out_data_reg <= out_data_next;
    end

    a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_READ) |-> (addr_reg < IDX_W'(BUF_SIZE)))
        else $error("payload read beyond frame buffer");

endmodule

[bench/api_rx_frame_parser_chk.sv]
module api_rx_frame_parser_chk (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [15:0]         cfg_write_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  arpf_pkg::in_word_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  arpf_pkg::out_word_t out_data,
    output int                  mismatches,
    output int                  due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_LEN_LO = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    logic [1:0]          phase;
    logic [7:0]          frame_mem [arpf_pkg::BUF_SIZE_DEF];
    logic [6:0]          wr_idx;
    logic [15:0]         len_word;
    logic [6:0]          frame_len;
    logic [7:0]          byte_sum;
    logic [15:0]         idle_ticks;
    logic [15:0]         timeout_ticks;
    arpf_pkg::out_word_t due_words [$];

    function automatic void push_due(logic [2:0] st, logic [7:0] b, logic last);
        arpf_pkg::out_word_t w;
        w.status       = st;
        w.payload_byte = b;
        w.last_flag    = last;
        due_words.push_back(w);
    endfunction

    function automatic void store_byte(logic [7:0] b);
        if (wr_idx < arpf_pkg::BUF_SIZE_DEF)
            frame_mem[wr_idx] = b;
        wr_idx = wr_idx + 7'd1;
    endfunction

    // checksum first, then frame type, then payload presence
    function automatic void close_frame();
        logic [7:0] chk;
        int n;
        chk = frame_mem[int'(frame_len) - 1];
        if (8'(arpf_pkg::CHK_BASE - byte_sum) != chk)
            push_due(arpf_pkg::ST_CHECKSUM, 8'h00, 1'b1);
        else if (frame_mem[3] != arpf_pkg::RX_TYPE)
            push_due(arpf_pkg::ST_TYPE, 8'h00, 1'b1);
        else if (int'(frame_len) < arpf_pkg::PAY_OFFSET + 2)
            push_due(arpf_pkg::ST_EMPTY, 8'h00, 1'b1);
        else
        begin
            n = int'(frame_len) - 1 - arpf_pkg::PAY_OFFSET;
            for (int i = 0; i < n; i++)
                push_due(arpf_pkg::ST_PAYLOAD, frame_mem[arpf_pkg::PAY_OFFSET + i],
                         i == n - 1);
        end
    endfunction

    function automatic void parse_rx_word(arpf_pkg::in_word_t w);
        logic [16:0] next_idle;
        logic [16:0] total;
        if (w.operation == arpf_pkg::OP_TICK)
        begin
            if (phase != PH_WAIT)
            begin
                next_idle = {1'b0, idle_ticks} + 17'd1;
                if (next_idle > {1'b0, timeout_ticks})
                begin
                    phase      = PH_WAIT;
                    idle_ticks = '0;
                    push_due(arpf_pkg::ST_TIMEOUT, 8'h00, 1'b1);
                end
                else
                    idle_ticks = next_idle[15:0];
            end
        end
        else
        begin
            idle_ticks = '0;
            case (phase)
                PH_WAIT:
                begin
                    if (w.rx_byte == arpf_pkg::START_MARK)
                    begin
                        wr_idx   = '0;
                        byte_sum = '0;
                        store_byte(w.rx_byte);
                        phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    len_word = {w.rx_byte, 8'h00};
                    store_byte(w.rx_byte);
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_word[7:0] = w.rx_byte;
                    store_byte(w.rx_byte);
                    total = {1'b0, len_word} + 17'd4;
                    if (total > arpf_pkg::BUF_SIZE_DEF)
                    begin
                        phase = PH_WAIT;
                        push_due(arpf_pkg::ST_OVERFLOW, 8'h00, 1'b1);
                    end
                    else
                    begin
                        frame_len = total[6:0];
                        phase     = PH_BODY;
                    end
                end
                default:
                begin
                    store_byte(w.rx_byte);
                    if (wr_idx >= frame_len)
                    begin
                        phase = PH_WAIT;
                        close_frame();
                    end
                    else
                        byte_sum = byte_sum + w.rx_byte;
                end
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase         = PH_WAIT;
            wr_idx        = '0;
            len_word      = '0;
            frame_len     = '0;
            byte_sum      = '0;
            idle_ticks    = '0;
            timeout_ticks = arpf_pkg::TIMEOUT_RESET;
            foreach (frame_mem[k])
                frame_mem[k] = 8'h00;
            due_words.delete();
            mismatches = 0;
            due_count  = 0;
        end
        else
        begin
            if (cfg_write_en)
                timeout_ticks = cfg_write_data;
            // outputs are registered behind the job queue, so check before predicting
            if (out_valid && !out_stall)
            begin
                if (due_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: status %0d byte %02h last %0b",
                                 out_data.status, out_data.payload_byte, out_data.last_flag);
                end
                else
                begin
                    arpf_pkg::out_word_t exp_w;
                    exp_w = due_words.pop_front();
                    if (out_data.status !== exp_w.status
                        || out_data.payload_byte !== exp_w.payload_byte
                        || out_data.last_flag !== exp_w.last_flag)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%02h/%0b got %0d/%02h/%0b",
                                     exp_w.status, exp_w.payload_byte, exp_w.last_flag,
                                     out_data.status, out_data.payload_byte,
                                     out_data.last_flag);
                    end
                end
            end
            if (in_valid && !in_stall)
                parse_rx_word(in_data);
            due_count = due_words.size();
        end
    end

endmodule

[bench/api_rx_frame_parser_unit_tb.sv]
module api_rx_frame_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 16;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                cfg_write_en   = 1'b0;
    logic [15:0]         cfg_write_data = '0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    arpf_pkg::in_word_t  in_data        = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    arpf_pkg::out_word_t out_data;

    int mismatches;
    int due_count;
    int burst_left  = 0;
    int sent_words  = 0;
    int cur_timeout = int'(arpf_pkg::TIMEOUT_RESET);
    int stall_left  = 0;
    int stall_mode  = 0;
    int quiet       = 0;

    always #1 clk = ~clk;

    api_rx_frame_parser_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

    api_rx_frame_parser_chk i_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .mismatches     (mismatches),
        .due_count      (due_count)
    );

    // receiver: picks one of four stall densities, redrawn whenever its countdown runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(32, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_word(logic op, logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_data  <= {op, b};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        sent_words++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word(arpf_pkg::OP_BYTE, b);
    endtask

    task automatic send_tick();
        send_word(arpf_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (due_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_timeout   = int'(v);
    endtask

    // keep counts body words sent (data plus checksum); fewer than len+1 truncates
    task automatic send_frame(int len, logic [7:0] ftype, bit bad_sum, int keep);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] chk;
        sum = 8'h00;
        send_byte(arpf_pkg::START_MARK);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len + 4 > arpf_pkg::BUF_SIZE_DEF)
            return;
        for (int i = 0; i < len && i < keep; i++)
        begin
            if (i == 0)
                b = ftype;
            else if ($urandom_range(0, 15) == 0)
                b = arpf_pkg::START_MARK;
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b);
            sum = sum + b;
            if ($urandom_range(0, 19) == 0)
                send_tick();
        end
        if (keep <= len)
            return;
        chk = arpf_pkg::CHK_BASE - sum;
        if (bad_sum)
            chk = chk ^ (8'h01 << $urandom_range(0, 7));
        send_byte(chk);
    endtask

    task automatic random_frame();
        int pick;
        int len;
        logic [7:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 60 || (pick >= 90 && pick < 95 && cur_timeout > 40))
        begin
            if ($urandom_range(0, 29) == 0)
                len = 76;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(29, 76);
            else
                len = $urandom_range(13, 28);
            send_frame(len, arpf_pkg::RX_TYPE, 1'b0, len + 1);
        end
        else if (pick < 68)
        begin
            len = $urandom_range(0, 40);
            send_frame(len, 8'($urandom_range(0, 255)), 1'b1, len + 1);
        end
        else if (pick < 76)
        begin
            len = $urandom_range(1, 40);
            t = 8'($urandom_range(0, 255));
            if (t == arpf_pkg::RX_TYPE)
                t = t ^ 8'h01;
            send_frame(len, t, 1'b0, len + 1);
        end
        else if (pick < 84)
        begin
            len = $urandom_range(0, 12);
            send_frame(len, arpf_pkg::RX_TYPE, 1'b0, len + 1);
        end
        else if (pick < 90)
            send_frame($urandom_range(77, 65535), arpf_pkg::RX_TYPE, 1'b0, 0);
        else if (pick < 95)
        begin
            // frame cut short, then the line goes quiet
            len = $urandom_range(13, 30);
            send_frame(len, arpf_pkg::RX_TYPE, 1'b0, $urandom_range(0, len));
            repeat (cur_timeout + 1) send_tick();
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 1) == 0)
                    send_tick();
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 11) == 0)
            wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'hFFFF, arpf_pkg::RX_TYPE, 1'b0, 0);
        send_frame(0, arpf_pkg::RX_TYPE, 1'b0, 1);
        send_frame(13, arpf_pkg::RX_TYPE, 1'b0, 14);
        send_frame(77, arpf_pkg::RX_TYPE, 1'b0, 0);

        write_timeout(16'd1);
        send_frame(13, arpf_pkg::RX_TYPE, 1'b0, 2);
        send_tick();
        send_tick();
        while (sent_words < 180)
            random_frame();

        write_timeout(16'hFFFF);
        while (sent_words < 330)
            random_frame();

        write_timeout(16'($urandom_range(2, 30)));
        while (sent_words < 455)
            random_frame();

        wait_drained();
        if (mismatches == 0 && due_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
